// File: rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: rtl/core/plv_pkg.sv
package plv_pkg;

  localparam int unsigned MaxSamplesLog2 = 20;
  localparam int unsigned PhaseBits      = 16;
  localparam int unsigned TrigBits       = 16;
  localparam int unsigned PlvW           = 17;
  localparam int unsigned CountW         = MaxSamplesLog2 + 1;
  localparam int unsigned SumW           = TrigBits + MaxSamplesLog2 + 2;
  localparam int unsigned QueueDepth     = 4;
  localparam logic [31:0] PiQ30          = 32'd3373259426;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_X,
    BK_X2,
    BK_HMUL,
    BK_HDIV,
    BK_SMUL,
    BK_ACC,
    BK_DINIT,
    BK_DIV,
    BK_SQC,
    BK_SQS,
    BK_SQRT,
    BK_OUT
  } back_state_e;

  // one classified item for the back part
  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] r;
    logic        last;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// File: rtl/core/plv_front.sv
module plv_front #(
  parameter int unsigned PHASE_BITS = plv_pkg::PhaseBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic [PHASE_BITS-1:0] phase_a_i,
  input  logic [PHASE_BITS-1:0] phase_b_i,
  input  logic                  last_sample_i,
  input  plv_pkg::q_ctl_t       ctl_i,
  output plv_pkg::item_t        item_o
);

  logic [PHASE_BITS-1:0] d;
  logic [31:0]           u;
  logic [29:0]           r;

  always_comb begin
    d = phase_a_i - phase_b_i;
    u = 32'(d) << (32 - PHASE_BITS);
    r = u[29:0];
    item_o.quad = u[31:30];
    item_o.last = last_sample_i;
    if (r <= 30'h2000_0000) begin
      item_o.swap = 1'b0;
      item_o.r    = r;
    end else begin
      item_o.swap = 1'b1;
      item_o.r    = 30'((31'h4000_0000) - 31'(r));
    end
  end

  logic unused;
  assign unused = clk_i ^ rst_ni ^ start ^ ctl_i.push ^ ctl_i.full;

endmodule

// File: rtl/core/plv_queue.sv
module plv_queue #(
  parameter int unsigned DEPTH = plv_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  plv_pkg::item_t  item_i,
  input  logic            pop_i,
  output logic            empty_o,
  output logic            full_o,
  output plv_pkg::item_t  item_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  plv_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= AW'((32'(wp_q) + 1) % DEPTH);
      if (pop_i && !empty_o) rp_q <= AW'((32'(rp_q) + 1) % DEPTH);
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

endmodule

// File: rtl/core/plv_back.sv
module plv_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  plv_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic                         idle_o,
  output logic                         done_o,
  output logic [plv_pkg::PlvW-1:0]     plv_o,
  output logic [plv_pkg::CountW-1:0]   samples_used_o,
  output logic                         overflowed_o
);

  localparam int unsigned SW = plv_pkg::SumW;
  localparam int unsigned CW = plv_pkg::CountW;
  localparam int unsigned TB = plv_pkg::TrigBits;
  localparam logic [CW-1:0] Limit = CW'(64'd1 << plv_pkg::MaxSamplesLog2);
  localparam logic [31:0] One30 = 32'h4000_0000;

  // reciprocals for exact floor division of a 30-bit value by an odd constant
  localparam logic [31:0] Rcp1  = 32'h4000_0000;
  localparam logic [31:0] Rcp3  = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
  localparam logic [31:0] Rcp5  = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
  localparam logic [31:0] Rcp7  = 32'(((64'd1 << 33) + 64'd6) / 64'd7);
  localparam logic [31:0] Rcp9  = 32'(((64'd1 << 34) + 64'd8) / 64'd9);
  localparam logic [31:0] Rcp15 = 32'(((64'd1 << 34) + 64'd14) / 64'd15);
  localparam logic [31:0] Rcp21 = 32'(((64'd1 << 35) + 64'd20) / 64'd21);
  localparam logic [31:0] Rcp45 = 32'(((64'd1 << 36) + 64'd44) / 64'd45);

  plv_pkg::back_state_e st_q, st_d;
  plv_pkg::item_t       it_q;
  logic signed [SW-1:0] cs_q, sn_q;
  logic [CW-1:0]        cnt_q;
  logic                 ovf_q;

  // trig sequencer registers
  logic [2:0]  step_q;
  logic        phase_q;   // 0 sin, 1 cos
  logic [31:0] x_q, x2_q, t_q, s0_q;
  logic [29:0] h_q;

  // divider / sqrt registers
  logic [63:0]   num_q;
  logic [CW-1:0] rem_q;
  logic [31:0]   mc_q;
  logic [5:0]    bit_q;
  logic          dsel_q;
  logic [63:0]   sq_q, res_q, sbit_q;

  function automatic logic [TB:0] to_trig(input logic [31:0] v);
    logic [32:0] o;
    o = (33'(v) + (33'd1 << (29 - TB))) >> (30 - TB);
    if (o > (33'd1 << TB)) o = 33'd1 << TB;
    return o[TB:0];
  endfunction

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  always_comb begin
    ma = x2_q;
    mb = t_q;
    unique case (st_q)
      plv_pkg::BK_X:    begin ma = {2'b00, it_q.r}; mb = plv_pkg::PiQ30; end
      plv_pkg::BK_X2:   begin ma = x_q;  mb = x_q;  end
      plv_pkg::BK_SMUL: begin ma = x_q;  mb = t_q;  end
      plv_pkg::BK_SQC:  begin ma = mc_q; mb = mc_q; end
      plv_pkg::BK_SQS:  begin ma = num_q[31:0]; mb = num_q[31:0]; end
      default: ;
    endcase
    mp = 64'(ma) * 64'(mb);
  end

  // horner divisor k = 2^dsh * odd
  logic [1:0]  dsh;
  logic [31:0] dmul;
  logic [5:0]  dsft;
  always_comb begin
    dsh  = 2'd0;
    dmul = Rcp1;
    dsft = 6'd30;
    unique case ({phase_q, step_q})
      4'b0_000: begin dsh = 2'd3; dmul = Rcp9;  dsft = 6'd34; end
      4'b0_001: begin dsh = 2'd1; dmul = Rcp21; dsft = 6'd35; end
      4'b0_010: begin dsh = 2'd2; dmul = Rcp5;  dsft = 6'd33; end
      4'b0_011: begin dsh = 2'd1; dmul = Rcp3;  dsft = 6'd32; end
      4'b1_000: begin dsh = 2'd1; dmul = Rcp45; dsft = 6'd36; end
      4'b1_001: begin dsh = 2'd3; dmul = Rcp7;  dsft = 6'd33; end
      4'b1_010: begin dsh = 2'd1; dmul = Rcp15; dsft = 6'd34; end
      4'b1_011: begin dsh = 2'd2; dmul = Rcp3;  dsft = 6'd32; end
      4'b1_100: begin dsh = 2'd1; dmul = Rcp1;  dsft = 6'd30; end
      default: ;
    endcase
  end

  logic [29:0] hs;
  logic [61:0] qprod;
  logic [31:0] quot, tnew;
  always_comb begin
    hs    = h_q >> dsh;
    qprod = 62'(hs) * 62'(dmul);
    quot  = 32'(qprod >> dsft);
    tnew  = One30 - quot;
  end

  logic signed [SW-1:0] csv, snv, cvv, svv;
  logic [31:0] sfin, cfin;
  always_comb begin
    sfin = it_q.swap ? t_q : s0_q;
    cfin = it_q.swap ? s0_q : t_q;
    csv = SW'(to_trig(cfin));
    snv = SW'(to_trig(sfin));
    unique case (it_q.quad)
      2'd0: begin cvv = csv;  svv = snv;  end
      2'd1: begin cvv = -snv; svv = csv;  end
      2'd2: begin cvv = -csv; svv = -snv; end
      default: begin cvv = snv; svv = -csv; end
    endcase
  end

  logic [63:0] magc, mags;
  always_comb begin
    magc = cs_q[SW-1] ? 64'(-cs_q) : 64'(cs_q);
    mags = sn_q[SW-1] ? 64'(-sn_q) : 64'(sn_q);
  end

  logic [CW:0] rsh, rdif;
  logic        qbit;
  always_comb begin
    rsh  = {rem_q, num_q[63]};
    rdif = rsh - {1'b0, cnt_q};
    qbit = (rsh >= {1'b0, cnt_q});
  end

  logic [63:0] sum_rb;
  always_comb sum_rb = res_q + sbit_q;

  logic [63:0] pr;
  always_comb begin
    pr = (res_q + 64'h2000) >> 14;
    if (pr > 64'd65536) pr = 64'd65536;
  end

  assign idle_o = (st_q == plv_pkg::BK_IDLE) && empty_i;

  always_comb begin
    st_d  = st_q;
    pop_o = 1'b0;
    unique case (st_q)
      plv_pkg::BK_IDLE: if (!empty_i) begin
        pop_o = 1'b1;
        if (cnt_q < Limit) st_d = plv_pkg::BK_X;
        else if (item_i.last) st_d = plv_pkg::BK_DINIT;
      end
      plv_pkg::BK_X:    st_d = plv_pkg::BK_X2;
      plv_pkg::BK_X2:   st_d = plv_pkg::BK_HMUL;
      plv_pkg::BK_HMUL: st_d = plv_pkg::BK_HDIV;
      plv_pkg::BK_HDIV: begin
        if (!phase_q && step_q == 3'd3) st_d = plv_pkg::BK_SMUL;
        else if (phase_q && step_q == 3'd4) st_d = plv_pkg::BK_ACC;
        else st_d = plv_pkg::BK_HMUL;
      end
      plv_pkg::BK_SMUL:  st_d = plv_pkg::BK_HMUL;
      plv_pkg::BK_ACC:   st_d = it_q.last ? plv_pkg::BK_DINIT : plv_pkg::BK_IDLE;
      plv_pkg::BK_DINIT: st_d = plv_pkg::BK_DIV;
      plv_pkg::BK_DIV:   if (dsel_q && bit_q == 6'd63) st_d = plv_pkg::BK_SQC;
      plv_pkg::BK_SQC:   st_d = plv_pkg::BK_SQS;
      plv_pkg::BK_SQS:   st_d = plv_pkg::BK_SQRT;
      plv_pkg::BK_SQRT:  if (sbit_q[0]) st_d = plv_pkg::BK_OUT;
      plv_pkg::BK_OUT:   st_d = plv_pkg::BK_IDLE;
      default:           st_d = plv_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= plv_pkg::BK_IDLE;
      cs_q <= '0; sn_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      done_o <= 1'b0;
      plv_o <= '0; samples_used_o <= '0; overflowed_o <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_o <= 1'b0;
      if (st_q == plv_pkg::BK_IDLE && !empty_i && cnt_q >= Limit) ovf_q <= 1'b1;
      if (st_q == plv_pkg::BK_ACC) begin
        cs_q <= cs_q + cvv; sn_q <= sn_q + svv; cnt_q <= cnt_q + CW'(1);
      end
      if (st_q == plv_pkg::BK_OUT) begin
        done_o <= 1'b1;
        plv_o <= pr[plv_pkg::PlvW-1:0];
        samples_used_o <= cnt_q;
        overflowed_o <= ovf_q;
        cs_q <= '0; sn_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      plv_pkg::BK_IDLE: if (!empty_i) begin
        it_q <= item_i;
        step_q <= '0; phase_q <= 1'b0;
      end
      plv_pkg::BK_X:    x_q  <= 32'((mp + 64'h4000_0000) >> 31);
      plv_pkg::BK_X2:   x2_q <= mp[61:30];
      plv_pkg::BK_HMUL: h_q  <= (step_q == 3'd0) ? x2_q[29:0] : mp[59:30];
      plv_pkg::BK_HDIV: begin
        t_q <= tnew;
        if (phase_q || step_q != 3'd3) step_q <= step_q + 3'd1;
      end
      plv_pkg::BK_SMUL: begin
        s0_q <= mp[61:30]; phase_q <= 1'b1; step_q <= '0;
      end
      plv_pkg::BK_DINIT: begin
        num_q <= magc << (30 - TB);
        rem_q <= '0; bit_q <= '0; dsel_q <= 1'b0;
      end
      plv_pkg::BK_DIV: begin
        bit_q <= bit_q + 6'd1;
        if (bit_q == 6'd63 && !dsel_q) begin
          mc_q   <= {num_q[30:0], qbit};
          num_q  <= mags << (30 - TB);
          rem_q  <= '0;
          dsel_q <= 1'b1;
        end else begin
          num_q <= {num_q[62:0], qbit};
          rem_q <= qbit ? rdif[CW-1:0] : rsh[CW-1:0];
        end
      end
      plv_pkg::BK_SQC: sq_q <= mp;
      plv_pkg::BK_SQS: begin
        sq_q <= sq_q + mp; res_q <= '0; sbit_q <= 64'd1 << 62;
      end
      plv_pkg::BK_SQRT: begin
        if (sq_q >= sum_rb) begin
          sq_q  <= sq_q - sum_rb;
          res_q <= (res_q >> 1) + sbit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/phase_locking_value.sv
// channel | signals                              | handshake
// input   | phase_a_i phase_b_i last_sample_i     | start, taken when busy is low
// result  | plv_o samples_used_o overflowed_o     | done_o strobe, one cycle
// the back part holds one item at a time: two setup products, then mul/div horner steps
// an item past the sample limit is dropped and sets the overflow flag
// a last item adds two 64-step serial divides, two squares and a 32-step root,
// and done_o is registered in the output state after the root
// busy rises while the four-entry queue is full; reset clears all sums and the queue
// results cannot be stalled
module phase_locking_value #(
  parameter int unsigned PHASE_BITS = plv_pkg::PhaseBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [PHASE_BITS-1:0]      phase_a_i,
  input  logic [PHASE_BITS-1:0]      phase_b_i,
  input  logic                       last_sample_i,
  output logic                       done_o,
  output logic [plv_pkg::PlvW-1:0]   plv_o,
  output logic [plv_pkg::CountW-1:0] samples_used_o,
  output logic                       overflowed_o
);

  plv_pkg::item_t  fr_item, q_item;
  plv_pkg::q_ctl_t ctl;
  logic            q_empty, q_full, pop, idle;

  assign busy     = q_full;
  assign ctl.push = start && !busy;
  assign ctl.full = q_full;

  plv_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk_i, .rst_ni, .start, .phase_a_i, .phase_b_i, .last_sample_i,
    .ctl_i(ctl), .item_o(fr_item)
  );

  plv_queue u_queue (
    .clk_i, .rst_ni, .push_i(ctl.push), .item_i(fr_item), .pop_i(pop),
    .empty_o(q_empty), .full_o(q_full), .item_o(q_item)
  );

  plv_back u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .item_i(q_item), .pop_o(pop),
    .idle_o(idle), .done_o, .plv_o, .samples_used_o, .overflowed_o
  );

  logic unused;
  assign unused = idle;

endmodule

// File: rtl/core/plv_checker.sv
`include "assert_macros.svh"

module plv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [16:0] plv_o,
  input logic [20:0] samples_used_o
);

  `ASSERT_IMPL(plv_range, clk_i, rst_ni, done_o, plv_o <= 17'd65536)
  `ASSERT_IMPL(cnt_nonzero, clk_i, rst_ni, done_o, samples_used_o != 21'd0)
  `ASSERT_NEXT(done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

bind phase_locking_value plv_checker u_chk (
  .clk_i, .rst_ni, .done_o, .plv_o, .samples_used_o
);
